[rtl/config_text_tokenizer_macros.svh]
// Assertion macros for the configuration text tokenizer.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef CONFIG_TEXT_TOKENIZER_MACROS_SVH
`define CONFIG_TEXT_TOKENIZER_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CTT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define CTT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/ctt_pkg.sv]
// Types, character codes and classifiers for the configuration text tokenizer.
// No dependencies.
package ctt_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_item_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [1:0]  token_class;
		logic [7:0]  token_char;
		logic [15:0] start_offset;
		logic [15:0] start_line;
		logic        run_last;
	} token_item_t;

	typedef enum logic [5:0] {
		M_IDLE    = 6'b000001,
		M_COMMENT = 6'b000010,
		M_WORD    = 6'b000100,
		M_SLASH   = 6'b001000,
		M_STRING  = 6'b010000,
		M_QUOTE   = 6'b100000
	} mode_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [1:0] CLS_OP     = 2'd0;
	localparam logic [1:0] CLS_WORD   = 2'd1;
	localparam logic [1:0] CLS_STRING = 2'd2;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Result queue
	localparam int unsigned QDEPTH = 8;
	localparam int unsigned QPTR_W = 3;
	localparam int unsigned QCNT_W = 4;

	function automatic logic is_sep(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic is_op(input logic [7:0] c);
		return (c == 8'h2C) || (c == 8'h3D) || (c == 8'h28) || (c == 8'h29) ||
			(c == 8'h3B) || (c == 8'h7B) || (c == 8'h7D) || (c == 8'h3C) ||
			(c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == CH_SLASH) ||
			(c == 8'h3E);
	endfunction

endpackage

[rtl/config_text_tokenizer.sv]
// Configuration text tokenizer: top level, one byte in, up to three results out.
// Depends on ctt_pkg and config_text_tokenizer_macros.svh.
`include "config_text_tokenizer_macros.svh"

// Takes one byte of text per cycle while text_stall is low. An accepted byte is held
// in an input register, then decoded against the lexer state combinationally, and its
// zero to three results are written into an eight-entry result queue that delivers
// one result per cycle while token_stall is low. Bytes that give at most one result
// stream at one per cycle while token_stall is low; extra results of a byte wait in
// the queue. text_stall rises while the queue lacks room for three results of the
// byte in the input register plus three for a new byte. After an unterminated string
// the block swallows all input without results until reset. Offsets and lines
// saturate at 2^POSITION_BITS-1 and are shown clamped to 65535.
module config_text_tokenizer #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  ctt_pkg::text_item_t text_item,
	output logic                token_valid,
	input  logic                token_stall,
	output ctt_pkg::token_item_t token_item
);
	import ctt_pkg::*;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	logic                     v_s1;
	logic [7:0]               byte_s1;
	logic                     eot_s1;

	mode_t                    mode_q, mode_n;
	logic [POSITION_BITS-1:0] pos_q, pos_n;
	logic [POSITION_BITS-1:0] line_q, line_n;
	logic [POSITION_BITS-1:0] toff_q, toff_n;
	logic [POSITION_BITS-1:0] tline_q, tline_n;
	logic                     stop_q, stop_n;

	token_item_t              res [3];
	logic [1:0]               n_res;
	logic                     idle;
	logic [7:0]               c;

	token_item_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]        wr_q, rd_q;
	logic [QCNT_W-1:0]        cnt_q;
	logic                     accept, pop;

	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] clamp16(input logic [POSITION_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w[31:16] != 16'd0) ? 16'hFFFF : w[15:0];
	endfunction

	function automatic token_item_t mk_res(
		input logic [1:0]               kind,
		input logic [1:0]               cls,
		input logic [7:0]               ch,
		input logic [POSITION_BITS-1:0] off,
		input logic [POSITION_BITS-1:0] ln
	);
		token_item_t r;
		r.item_kind    = kind;
		r.token_class  = cls;
		r.token_char   = (kind == KIND_BYTE) ? ch : 8'd0;
		r.start_offset = clamp16(off);
		r.start_line   = clamp16(ln);
		r.run_last     = 1'b0;
		return r;
	endfunction

	assign accept     = text_valid && !text_stall;
	assign pop        = token_valid && !token_stall;
	assign text_stall = (5'(cnt_q) + (v_s1 ? 5'd3 : 5'd0)) > 5'(QDEPTH - 3);
	assign token_valid = cnt_q != '0;
	assign token_item  = mem_q[rd_q];
	assign c           = byte_s1;

	always_comb begin
		mode_n  = mode_q;
		pos_n   = pos_q;
		line_n  = line_q;
		toff_n  = toff_q;
		tline_n = tline_q;
		stop_n  = stop_q;
		res     = '{default: '0};
		n_res   = 2'd0;
		idle    = 1'b0;
		if (v_s1 && !stop_q) begin
			unique case (mode_q)
				M_COMMENT: begin
					if (c == CH_LF) begin
						mode_n = M_IDLE;
						line_n = sat_inc(line_q);
					end
				end
				M_WORD: begin
					if (is_sep(c) || is_op(c) || (c == CH_HASH)) begin
						res[n_res] = mk_res(KIND_END, CLS_WORD, 8'd0, toff_q, tline_q);
						n_res = n_res + 2'd1;
						idle = 1'b1;
					end else begin
						res[n_res] = mk_res(KIND_BYTE, CLS_WORD, c, toff_q, tline_q);
						n_res = n_res + 2'd1;
					end
				end
				M_SLASH: begin
					if (c == CH_SLASH) begin
						mode_n = M_COMMENT;
					end else begin
						res[n_res] = mk_res(KIND_BYTE, CLS_OP, CH_SLASH, toff_q, tline_q);
						n_res = n_res + 2'd1;
						idle = 1'b1;
					end
				end
				M_STRING: begin
					if (c == CH_QUOTE) begin
						mode_n = M_QUOTE;
					end else begin
						res[n_res] = mk_res(KIND_BYTE, CLS_STRING, c, toff_q, tline_q);
						n_res = n_res + 2'd1;
					end
				end
				M_QUOTE: begin
					if (c == CH_QUOTE) begin
						res[n_res] = mk_res(KIND_BYTE, CLS_STRING, CH_QUOTE, toff_q, tline_q);
						n_res = n_res + 2'd1;
						mode_n = M_STRING;
					end else begin
						res[n_res] = mk_res(KIND_END, CLS_STRING, 8'd0, toff_q, tline_q);
						n_res = n_res + 2'd1;
						idle = 1'b1;
					end
				end
				default: idle = 1'b1;
			endcase

			if (idle) begin
				mode_n = M_IDLE;
				priority if (is_sep(c)) begin
					if (c == CH_LF)
						line_n = sat_inc(line_q);
				end else if (c == CH_HASH) begin
					mode_n = M_COMMENT;
				end else if (c == CH_SLASH) begin
					mode_n  = M_SLASH;
					toff_n  = pos_q;
					tline_n = line_q;
				end else if (is_op(c)) begin
					res[n_res] = mk_res(KIND_BYTE, CLS_OP, c, pos_q, line_q);
					n_res = n_res + 2'd1;
				end else if (c == CH_QUOTE) begin
					mode_n  = M_STRING;
					toff_n  = pos_q;
					tline_n = line_q;
				end else begin
					mode_n  = M_WORD;
					toff_n  = pos_q;
					tline_n = line_q;
					res[n_res] = mk_res(KIND_BYTE, CLS_WORD, c, pos_q, line_q);
					n_res = n_res + 2'd1;
				end
			end

			pos_n = sat_inc(pos_q);

			if (eot_s1) begin
				unique case (mode_n)
					M_WORD: begin
						res[n_res] = mk_res(KIND_END, CLS_WORD, 8'd0, toff_n, tline_n);
						n_res = n_res + 2'd1;
					end
					M_SLASH: begin
						res[n_res] = mk_res(KIND_BYTE, CLS_OP, CH_SLASH, toff_n, tline_n);
						n_res = n_res + 2'd1;
					end
					M_STRING: begin
						res[n_res] = mk_res(KIND_ERROR, CLS_STRING, 8'd0, toff_n, tline_n);
						n_res = n_res + 2'd1;
						stop_n = 1'b1;
					end
					M_QUOTE: begin
						res[n_res] = mk_res(KIND_END, CLS_STRING, 8'd0, toff_n, tline_n);
						n_res = n_res + 2'd1;
					end
					default: ;
				endcase
				mode_n = M_IDLE;
				pos_n  = '0;
				line_n = '0;
			end

			if (n_res != 2'd0)
				res[n_res - 2'd1].run_last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_item.text_byte;
			eot_s1  <= text_item.end_of_text;
		end
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < n_res)
				mem_q[wr_q + QPTR_W'(i)] <= res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			mode_q  <= M_IDLE;
			pos_q   <= '0;
			line_q  <= '0;
			toff_q  <= '0;
			tline_q <= '0;
			stop_q  <= 1'b0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			v_s1    <= accept;
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			line_q  <= line_n;
			toff_q  <= toff_n;
			tline_q <= tline_n;
			stop_q  <= stop_n;
			wr_q    <= wr_q + QPTR_W'(n_res);
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q   <= cnt_q + QCNT_W'(n_res) - QCNT_W'(pop);
		end
	end

	`CTT_NEVER(a_queue_bound, cnt_q > QCNT_W'(QDEPTH), "result queue overflow")
	`CTT_ASSERT(a_stop_holds, stop_q |=> stop_q, "stop flag cleared without reset")
	`CTT_ASSERT(a_stopped_quiet, stop_q |-> (n_res == 2'd0), "results while stopped")
	`CTT_ASSERT(a_eot_idle, (v_s1 && eot_s1) |=> (mode_q == M_IDLE && pos_q == '0),
		"lexer not back to idle after end of text")
	`CTT_NEVER(a_no_write_when_full, (n_res != 2'd0) &&
		((5'(cnt_q) + 5'(n_res)) > 5'(QDEPTH)), "results written with no room")

endmodule
